// ----- sv/fesg_pkg.sv -----
// Shared types, widths and microcode encodings for the filled ellipse span generator.
`default_nettype none

package fesg_pkg;

    localparam int COORD_BITS  = 10;
    localparam int RADIUS_BITS = 9;
    localparam int COLOR_BITS  = 8;
    localparam int OUT_BITS    = 12;
    localparam int SQ_BITS     = 2 * RADIUS_BITS;
    localparam int PROD_BITS   = 2 * SQ_BITS;
    localparam int CALC_BITS   = (COORD_BITS + 1 > OUT_BITS) ? COORD_BITS + 1 : OUT_BITS;

    localparam int STEP_BITS = 4;

    localparam logic [STEP_BITS-1:0] STEP_IDLE     = 4'd0;
    localparam logic [STEP_BITS-1:0] STEP_START    = 4'd1;
    localparam logic [STEP_BITS-1:0] STEP_RY2      = 4'd2;
    localparam logic [STEP_BITS-1:0] STEP_Y2       = 4'd3;
    localparam logic [STEP_BITS-1:0] STEP_LIMIT    = 4'd4;
    localparam logic [STEP_BITS-1:0] STEP_YTERM    = 4'd5;
    localparam logic [STEP_BITS-1:0] STEP_LOOP     = 4'd6;
    localparam logic [STEP_BITS-1:0] STEP_XTERM    = 4'd7;
    localparam logic [STEP_BITS-1:0] STEP_TEST     = 4'd8;
    localparam logic [STEP_BITS-1:0] STEP_DEC      = 4'd9;
    localparam logic [STEP_BITS-1:0] STEP_COMMIT   = 4'd10;
    localparam logic [STEP_BITS-1:0] STEP_UPPER    = 4'd11;
    localparam logic [STEP_BITS-1:0] STEP_LOWER    = 4'd12;
    localparam logic [STEP_BITS-1:0] STEP_ROW0     = 4'd13;

    typedef enum logic [2:0] {
        ACT_NOP,
        ACT_LATCH,
        ACT_START,
        ACT_DEC_X,
        ACT_COMMIT,
        ACT_EMIT_ROW0,
        ACT_EMIT_UPPER,
        ACT_EMIT_LOWER
    } t_act;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_Y_ZERO,
        COND_X_ZERO,
        COND_FIT
    } t_cond;

    typedef enum logic [2:0] {
        A_RX,
        A_RY,
        A_Y,
        A_X,
        A_RX2,
        A_Y2,
        A_X2
    } t_asel;

    typedef enum logic [1:0] {
        B_SQ,
        B_RX2,
        B_RY2
    } t_bsel;

    typedef enum logic [2:0] {
        D_NONE,
        D_RX2,
        D_RY2,
        D_Y2,
        D_LIMIT,
        D_YTERM,
        D_X2,
        D_PROD
    } t_dst;

    typedef struct packed {
        t_act                 act;
        t_cond                cond;
        logic [STEP_BITS-1:0] target;
        t_asel                asel;
        t_bsel                bsel;
        t_dst                 dst;
    } t_ctrl;

    typedef struct packed {
        t_ctrl word;
        logic  fire;
    } t_cmd;

    typedef struct packed {
        logic y_zero;
        logic x_zero;
        logic fit;
        logic out_busy;
    } t_stat;

endpackage

`default_nettype wire

// ----- sv/fesg_ucode_rom.sv -----
// Microcode table: one control word per sequencer step.
`default_nettype none

module fesg_ucode_rom (
    input  wire logic [fesg_pkg::STEP_BITS-1:0] i_step,
    output fesg_pkg::t_ctrl                     o_word
);

    function automatic fesg_pkg::t_ctrl mk(
        input fesg_pkg::t_act                 act,
        input fesg_pkg::t_cond                cond,
        input logic [fesg_pkg::STEP_BITS-1:0] target,
        input fesg_pkg::t_asel                asel,
        input fesg_pkg::t_bsel                bsel,
        input fesg_pkg::t_dst                 dst
    );
        fesg_pkg::t_ctrl w;
        w.act    = act;
        w.cond   = cond;
        w.target = target;
        w.asel   = asel;
        w.bsel   = bsel;
        w.dst    = dst;
        return w;
    endfunction

    always_comb begin
        case (i_step)
            fesg_pkg::STEP_IDLE: begin
                o_word = mk(fesg_pkg::ACT_LATCH, fesg_pkg::COND_NO_INPUT, fesg_pkg::STEP_IDLE,
                            fesg_pkg::A_RX, fesg_pkg::B_SQ, fesg_pkg::D_NONE);
            end
            fesg_pkg::STEP_START: begin
                o_word = mk(fesg_pkg::ACT_START, fesg_pkg::COND_Y_ZERO, fesg_pkg::STEP_ROW0,
                            fesg_pkg::A_RX, fesg_pkg::B_SQ, fesg_pkg::D_RX2);
            end
            fesg_pkg::STEP_RY2: begin
                o_word = mk(fesg_pkg::ACT_NOP, fesg_pkg::COND_NEXT, fesg_pkg::STEP_IDLE,
                            fesg_pkg::A_RY, fesg_pkg::B_SQ, fesg_pkg::D_RY2);
            end
            fesg_pkg::STEP_Y2: begin
                o_word = mk(fesg_pkg::ACT_NOP, fesg_pkg::COND_NEXT, fesg_pkg::STEP_IDLE,
                            fesg_pkg::A_Y, fesg_pkg::B_SQ, fesg_pkg::D_Y2);
            end
            fesg_pkg::STEP_LIMIT: begin
                o_word = mk(fesg_pkg::ACT_NOP, fesg_pkg::COND_NEXT, fesg_pkg::STEP_IDLE,
                            fesg_pkg::A_RX2, fesg_pkg::B_RY2, fesg_pkg::D_LIMIT);
            end
            fesg_pkg::STEP_YTERM: begin
                o_word = mk(fesg_pkg::ACT_NOP, fesg_pkg::COND_NEXT, fesg_pkg::STEP_IDLE,
                            fesg_pkg::A_Y2, fesg_pkg::B_RX2, fesg_pkg::D_YTERM);
            end
            fesg_pkg::STEP_LOOP: begin
                o_word = mk(fesg_pkg::ACT_NOP, fesg_pkg::COND_X_ZERO, fesg_pkg::STEP_COMMIT,
                            fesg_pkg::A_X, fesg_pkg::B_SQ, fesg_pkg::D_X2);
            end
            fesg_pkg::STEP_XTERM: begin
                o_word = mk(fesg_pkg::ACT_NOP, fesg_pkg::COND_NEXT, fesg_pkg::STEP_IDLE,
                            fesg_pkg::A_X2, fesg_pkg::B_RY2, fesg_pkg::D_PROD);
            end
            fesg_pkg::STEP_TEST: begin
                o_word = mk(fesg_pkg::ACT_NOP, fesg_pkg::COND_FIT, fesg_pkg::STEP_COMMIT,
                            fesg_pkg::A_RX, fesg_pkg::B_SQ, fesg_pkg::D_NONE);
            end
            fesg_pkg::STEP_DEC: begin
                o_word = mk(fesg_pkg::ACT_DEC_X, fesg_pkg::COND_ALWAYS, fesg_pkg::STEP_LOOP,
                            fesg_pkg::A_RX, fesg_pkg::B_SQ, fesg_pkg::D_NONE);
            end
            fesg_pkg::STEP_COMMIT: begin
                o_word = mk(fesg_pkg::ACT_COMMIT, fesg_pkg::COND_NEXT, fesg_pkg::STEP_IDLE,
                            fesg_pkg::A_RX, fesg_pkg::B_SQ, fesg_pkg::D_NONE);
            end
            fesg_pkg::STEP_UPPER: begin
                o_word = mk(fesg_pkg::ACT_EMIT_UPPER, fesg_pkg::COND_NEXT, fesg_pkg::STEP_IDLE,
                            fesg_pkg::A_RX, fesg_pkg::B_SQ, fesg_pkg::D_NONE);
            end
            fesg_pkg::STEP_LOWER: begin
                o_word = mk(fesg_pkg::ACT_EMIT_LOWER, fesg_pkg::COND_ALWAYS, fesg_pkg::STEP_IDLE,
                            fesg_pkg::A_RX, fesg_pkg::B_SQ, fesg_pkg::D_NONE);
            end
            fesg_pkg::STEP_ROW0: begin
                o_word = mk(fesg_pkg::ACT_EMIT_ROW0, fesg_pkg::COND_ALWAYS, fesg_pkg::STEP_IDLE,
                            fesg_pkg::A_RX, fesg_pkg::B_SQ, fesg_pkg::D_NONE);
            end
            default: begin
                o_word = mk(fesg_pkg::ACT_NOP, fesg_pkg::COND_ALWAYS, fesg_pkg::STEP_IDLE,
                            fesg_pkg::A_RX, fesg_pkg::B_SQ, fesg_pkg::D_NONE);
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/fesg_sequencer.sv -----
// Step counter with conditional jumps and microcode fetch.
`default_nettype none

module fesg_sequencer (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire fesg_pkg::t_stat i_stat,
    output fesg_pkg::t_cmd       o_cmd
);

    logic [fesg_pkg::STEP_BITS-1:0] r_step;
    logic [fesg_pkg::STEP_BITS-1:0] n_step;
    logic [fesg_pkg::STEP_BITS-1:0] step_inc;
    fesg_pkg::t_ctrl                word;
    logic                           is_emit;
    logic                           fire;
    logic                           take;

    fesg_ucode_rom u_rom (
        .i_step (r_step),
        .o_word (word)
    );

    assign is_emit  = (word.act == fesg_pkg::ACT_EMIT_ROW0) ||
                      (word.act == fesg_pkg::ACT_EMIT_UPPER) ||
                      (word.act == fesg_pkg::ACT_EMIT_LOWER);
    assign fire     = !(is_emit && i_stat.out_busy);
    assign step_inc = r_step + 1'b1;

    always_comb begin
        case (word.cond)
            fesg_pkg::COND_NEXT:     take = 1'b0;
            fesg_pkg::COND_ALWAYS:   take = 1'b1;
            fesg_pkg::COND_NO_INPUT: take = !i_in_valid;
            fesg_pkg::COND_Y_ZERO:   take = i_stat.y_zero;
            fesg_pkg::COND_X_ZERO:   take = i_stat.x_zero;
            fesg_pkg::COND_FIT:      take = i_stat.fit;
            default:                 take = 1'b1;
        endcase
        if (!fire) begin
            n_step = r_step;
        end else if (take) begin
            n_step = word.target;
        end else begin
            n_step = step_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= fesg_pkg::STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_cmd.word = word;
    assign o_cmd.fire = fire;

endmodule

`default_nettype wire

// ----- sv/fesg_datapath.sv -----
// Datapath: operand registers, shared multiplier, row state and output register.
`default_nettype none

module fesg_datapath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire fesg_pkg::t_cmd                      i_cmd,
    output fesg_pkg::t_stat                          o_stat,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [fesg_pkg::COORD_BITS-1:0]     i_center_x,
    input  wire logic [fesg_pkg::COORD_BITS-1:0]     i_center_y,
    input  wire logic [fesg_pkg::RADIUS_BITS-1:0]    i_radius_horizontal,
    input  wire logic [fesg_pkg::RADIUS_BITS-1:0]    i_radius_vertical,
    input  wire logic [fesg_pkg::COLOR_BITS-1:0]     i_fill_color,
    input  wire logic [fesg_pkg::RADIUS_BITS-1:0]    i_row_offset,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [fesg_pkg::OUT_BITS-1:0]     o_span_row,
    output logic signed [fesg_pkg::OUT_BITS-1:0]     o_span_left,
    output logic signed [fesg_pkg::OUT_BITS-1:0]     o_span_right,
    output logic [fesg_pkg::COLOR_BITS-1:0]          o_span_color,
    output logic                                     o_span_last
);

    localparam int RB = fesg_pkg::RADIUS_BITS;
    localparam int SB = fesg_pkg::SQ_BITS;
    localparam int PB = fesg_pkg::PROD_BITS;
    localparam int CB = fesg_pkg::CALC_BITS;
    localparam int OB = fesg_pkg::OUT_BITS;

    logic [fesg_pkg::COORD_BITS-1:0] r_cx;
    logic [fesg_pkg::COORD_BITS-1:0] r_cy;
    logic [RB-1:0]                   r_rx;
    logic [RB-1:0]                   r_ry;
    logic [fesg_pkg::COLOR_BITS-1:0] r_color;
    logic [RB-1:0]                   r_y;
    logic [RB-1:0]                   r_x;
    logic [RB-1:0]                   r_hw;
    logic [RB-1:0]                   r_step;
    logic [SB-1:0]                   r_rx2;
    logic [SB-1:0]                   r_ry2;
    logic [SB-1:0]                   r_y2;
    logic [SB-1:0]                   r_x2;
    logic [PB-1:0]                   r_limit;
    logic [PB-1:0]                   r_yterm;
    logic [PB-1:0]                   r_prod;
    logic                            r_out_valid;
    logic [OB-1:0]                   r_row;
    logic [OB-1:0]                   r_left;
    logic [OB-1:0]                   r_right;
    logic [fesg_pkg::COLOR_BITS-1:0] r_span_color;
    logic                            r_last;

    logic [SB-1:0] mul_a;
    logic [SB-1:0] mul_b;
    logic [PB-1:0] product;
    logic [PB:0]   test_sum;
    logic [RB:0]   hw_inc;
    logic [RB:0]   step_ext;
    logic [RB:0]   start_diff;
    logic [RB-1:0] start;
    logic          accept;
    logic          act_fire;
    logic          emit;
    logic          emit_row0;
    logic          emit_lower;
    logic [RB-1:0] emit_hw;
    logic [CB-1:0] cx_ext;
    logic [CB-1:0] cy_ext;
    logic [CB-1:0] y_ext;
    logic [CB-1:0] hw_ext;
    logic [CB-1:0] row_calc;
    logic [CB-1:0] left_calc;
    logic [CB-1:0] right_calc;

    assign o_in_ready = (i_cmd.word.act == fesg_pkg::ACT_LATCH);
    assign accept     = o_in_ready && i_in_valid;
    assign act_fire   = i_cmd.fire;

    always_comb begin
        case (i_cmd.word.asel)
            fesg_pkg::A_RX:  mul_a = SB'(r_rx);
            fesg_pkg::A_RY:  mul_a = SB'(r_ry);
            fesg_pkg::A_Y:   mul_a = SB'(r_y);
            fesg_pkg::A_X:   mul_a = SB'(r_x);
            fesg_pkg::A_RX2: mul_a = r_rx2;
            fesg_pkg::A_Y2:  mul_a = r_y2;
            fesg_pkg::A_X2:  mul_a = r_x2;
            default:         mul_a = '0;
        endcase
        case (i_cmd.word.bsel)
            fesg_pkg::B_SQ:  mul_b = mul_a;
            fesg_pkg::B_RX2: mul_b = r_rx2;
            fesg_pkg::B_RY2: mul_b = r_ry2;
            default:         mul_b = '0;
        endcase
    end

    assign product  = PB'(mul_a) * PB'(mul_b);
    assign test_sum = {1'b0, r_prod} + {1'b0, r_yterm};

    assign o_stat.y_zero   = (r_y == '0);
    assign o_stat.x_zero   = (r_x == '0);
    assign o_stat.fit      = (test_sum <= {1'b0, r_limit});
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    assign hw_inc     = {1'b0, r_hw} + 1'b1;
    assign step_ext   = {1'b0, r_step};
    assign start_diff = hw_inc - step_ext;

    always_comb begin
        if (step_ext > hw_inc) begin
            start = '0;
        end else if (start_diff[RB]) begin
            start = '1;
        end else begin
            start = start_diff[RB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cx    <= i_center_x;
            r_cy    <= i_center_y;
            r_rx    <= i_radius_horizontal;
            r_ry    <= i_radius_vertical;
            r_color <= i_fill_color;
            r_y     <= i_row_offset;
        end
        case (i_cmd.word.dst)
            fesg_pkg::D_RX2:   r_rx2   <= product[SB-1:0];
            fesg_pkg::D_RY2:   r_ry2   <= product[SB-1:0];
            fesg_pkg::D_Y2:    r_y2    <= product[SB-1:0];
            fesg_pkg::D_LIMIT: r_limit <= product;
            fesg_pkg::D_YTERM: r_yterm <= product;
            fesg_pkg::D_X2:    r_x2    <= product[SB-1:0];
            fesg_pkg::D_PROD:  r_prod  <= product;
            default: begin
            end
        endcase
        if (act_fire && i_cmd.word.act == fesg_pkg::ACT_START) begin
            r_x <= start;
        end else if (act_fire && i_cmd.word.act == fesg_pkg::ACT_DEC_X) begin
            r_x <= r_x - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw   <= '0;
            r_step <= '0;
        end else if (act_fire && i_cmd.word.act == fesg_pkg::ACT_COMMIT) begin
            r_hw   <= r_x;
            r_step <= (r_x > r_hw) ? '0 : (r_hw - r_x);
        end else if (act_fire && i_cmd.word.act == fesg_pkg::ACT_EMIT_ROW0) begin
            r_hw   <= r_rx;
            r_step <= '0;
        end
    end

    assign emit_row0  = (i_cmd.word.act == fesg_pkg::ACT_EMIT_ROW0);
    assign emit_lower = (i_cmd.word.act == fesg_pkg::ACT_EMIT_LOWER);
    assign emit       = act_fire && (emit_row0 || emit_lower ||
                                     i_cmd.word.act == fesg_pkg::ACT_EMIT_UPPER);
    assign emit_hw    = emit_row0 ? r_rx : r_hw;

    assign cx_ext = CB'(r_cx);
    assign cy_ext = CB'(r_cy);
    assign y_ext  = CB'(r_y);
    assign hw_ext = CB'(emit_hw);

    always_comb begin
        if (emit_row0) begin
            row_calc = cy_ext;
        end else if (emit_lower) begin
            row_calc = cy_ext + y_ext;
        end else begin
            row_calc = cy_ext - y_ext;
        end
    end

    assign left_calc  = cx_ext - hw_ext;
    assign right_calc = cx_ext + hw_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_row        <= row_calc[OB-1:0];
            r_left       <= left_calc[OB-1:0];
            r_right      <= right_calc[OB-1:0];
            r_span_color <= r_color;
            r_last       <= emit_row0 || emit_lower;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_span_row   = r_row;
    assign o_span_left  = r_left;
    assign o_span_right = r_right;
    assign o_span_color = r_span_color;
    assign o_span_last  = r_last;

endmodule

`default_nettype wire

// ----- sv/filled_ellipse_span_generator_top.sv -----
// Top level of the filled ellipse span generator: sequencer plus datapath.
//
// Channel   Direction  Handshake                 Beat payload
// in        input      i_in_valid / o_in_ready   centre, radii, color, row offset
// out       output     o_out_valid / i_out_ready span row, left, right, color, last
//
// Row 0 gives one beat.
// Other rows search the half width downwards from the kept half width and step;
// the single shared multiplier is used once per microcode step. Each row gives two beats.
// Reset clears the step counter, the kept half width and step, and the out valid.
// A full output register that is not taken holds the sequencer at its emit step.
`default_nettype none

module filled_ellipse_span_generator_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [fesg_pkg::COORD_BITS-1:0]     i_center_x,
    input  wire logic [fesg_pkg::COORD_BITS-1:0]     i_center_y,
    input  wire logic [fesg_pkg::RADIUS_BITS-1:0]    i_radius_horizontal,
    input  wire logic [fesg_pkg::RADIUS_BITS-1:0]    i_radius_vertical,
    input  wire logic [fesg_pkg::COLOR_BITS-1:0]     i_fill_color,
    input  wire logic [fesg_pkg::RADIUS_BITS-1:0]    i_row_offset,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [fesg_pkg::OUT_BITS-1:0]     o_span_row,
    output logic signed [fesg_pkg::OUT_BITS-1:0]     o_span_left,
    output logic signed [fesg_pkg::OUT_BITS-1:0]     o_span_right,
    output logic [fesg_pkg::COLOR_BITS-1:0]          o_span_color,
    output logic                                     o_span_last
);

    fesg_pkg::t_cmd  cmd;
    fesg_pkg::t_stat stat;

    fesg_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fesg_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_center_x          (i_center_x),
        .i_center_y          (i_center_y),
        .i_radius_horizontal (i_radius_horizontal),
        .i_radius_vertical   (i_radius_vertical),
        .i_fill_color        (i_fill_color),
        .i_row_offset        (i_row_offset),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_span_row          (o_span_row),
        .o_span_left         (o_span_left),
        .o_span_right        (o_span_right),
        .o_span_color        (o_span_color),
        .o_span_last         (o_span_last)
    );

endmodule

`default_nettype wire

// ----- bench/tb_filled_ellipse_span_generator_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the filled ellipse span generator: row requests in, spans out.
module tb_filled_ellipse_span_generator_top;

    localparam int COORD_BITS  = fesg_pkg::COORD_BITS;
    localparam int RADIUS_BITS = fesg_pkg::RADIUS_BITS;
    localparam int COLOR_BITS  = fesg_pkg::COLOR_BITS;
    localparam int OUT_BITS    = fesg_pkg::OUT_BITS;
    localparam int IDLE_LIMIT  = 12000;
    localparam int TAIL_CYCLES = 40;
    localparam int ITEM_TARGET = 750;
    localparam int MAX_REPORTS = 10;
    localparam int RADIUS_MAX  = (1 << RADIUS_BITS) - 1;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int COLOR_MAX   = (1 << COLOR_BITS) - 1;

    typedef struct {
        logic [COORD_BITS-1:0]  cx;
        logic [COORD_BITS-1:0]  cy;
        logic [RADIUS_BITS-1:0] rx;
        logic [RADIUS_BITS-1:0] ry;
        logic [COLOR_BITS-1:0]  color;
        logic [RADIUS_BITS-1:0] y;
        bit                     drain;
    } t_row_req;

    typedef struct {
        logic signed [OUT_BITS-1:0] row;
        logic signed [OUT_BITS-1:0] left;
        logic signed [OUT_BITS-1:0] right;
        logic [COLOR_BITS-1:0]      color;
        logic                       last;
    } t_span;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_ONE_IN_FOUR,
        READY_LONG_STALL
    } t_ready_mode;

    logic                          i_clk               = 1'b0;
    logic                          i_rst_n             = 1'b0;
    logic                          i_in_valid          = 1'b0;
    logic                          o_in_ready;
    logic [COORD_BITS-1:0]         i_center_x          = '0;
    logic [COORD_BITS-1:0]         i_center_y          = '0;
    logic [RADIUS_BITS-1:0]        i_radius_horizontal = '0;
    logic [RADIUS_BITS-1:0]        i_radius_vertical   = '0;
    logic [COLOR_BITS-1:0]         i_fill_color        = '0;
    logic [RADIUS_BITS-1:0]        i_row_offset        = '0;
    logic                          o_out_valid;
    logic                          i_out_ready         = 1'b0;
    logic signed [OUT_BITS-1:0]    o_span_row;
    logic signed [OUT_BITS-1:0]    o_span_left;
    logic signed [OUT_BITS-1:0]    o_span_right;
    logic [COLOR_BITS-1:0]         o_span_color;
    logic                          o_span_last;

    t_row_req               row_reqs[$];
    t_span                  expected_spans[$];
    logic [RADIUS_BITS-1:0] kept_half     = '0;
    logic [RADIUS_BITS-1:0] kept_step     = '0;
    int                     span_errors   = 0;
    int                     idle_cycles   = 0;
    bit                     in_beat_taken = 1'b0;
    int                     burst_left    = 0;
    int                     gap_left      = 0;
    t_ready_mode            ready_mode    = READY_ALWAYS;
    int                     ready_count   = 0;
    int                     stall_left    = 0;

    filled_ellipse_span_generator_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_center_x          (i_center_x),
        .i_center_y          (i_center_y),
        .i_radius_horizontal (i_radius_horizontal),
        .i_radius_vertical   (i_radius_vertical),
        .i_fill_color        (i_fill_color),
        .i_row_offset        (i_row_offset),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_span_row          (o_span_row),
        .o_span_left         (o_span_left),
        .o_span_right        (o_span_right),
        .o_span_color        (o_span_color),
        .o_span_last         (o_span_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_span make_span(input logic [OUT_BITS-1:0] row,
                                        input logic [COORD_BITS-1:0] cx,
                                        input logic [RADIUS_BITS-1:0] hw,
                                        input logic [COLOR_BITS-1:0] color,
                                        input logic last);
        t_span s;
        s.row   = row;
        s.left  = OUT_BITS'(cx) - OUT_BITS'(hw);
        s.right = OUT_BITS'(cx) + OUT_BITS'(hw);
        s.color = color;
        s.last  = last;
        return s;
    endfunction

    task automatic predict_spans(input t_row_req r);
        longint unsigned rx2;
        longint unsigned ry2;
        longint unsigned bound;
        longint unsigned yterm;
        longint unsigned hw;
        longint unsigned x;
        if (r.y == 0) begin
            kept_half = r.rx;
            kept_step = '0;
            expected_spans.push_back(make_span(OUT_BITS'(r.cy), r.cx, r.rx, r.color, 1'b1));
            return;
        end
        rx2   = longint'(r.rx) * longint'(r.rx);
        ry2   = longint'(r.ry) * longint'(r.ry);
        bound = rx2 * ry2;
        yterm = longint'(r.y) * longint'(r.y) * rx2;
        hw    = kept_half;
        if (longint'(kept_step) > hw + 1) begin
            x = 0;
        end else begin
            x = hw + 1 - longint'(kept_step);
            if (x > RADIUS_MAX) x = RADIUS_MAX;
        end
        while (x > 0 && x * x * ry2 + yterm > bound) x--;
        kept_step = (x > hw) ? '0 : RADIUS_BITS'(hw - x);
        kept_half = RADIUS_BITS'(x);
        expected_spans.push_back(make_span(OUT_BITS'(r.cy) - OUT_BITS'(r.y), r.cx,
                                           kept_half, r.color, 1'b0));
        expected_spans.push_back(make_span(OUT_BITS'(r.cy) + OUT_BITS'(r.y), r.cx,
                                           kept_half, r.color, 1'b1));
    endtask

    task automatic note_error(input string msg);
        span_errors++;
        if (span_errors <= MAX_REPORTS) $display("%s", msg);
    endtask

    task automatic queue_row(input int cx, input int cy, input int rx, input int ry,
                             input int color, input int y, input bit drain = 1'b0);
        t_row_req r;
        r.cx    = COORD_BITS'(cx);
        r.cy    = COORD_BITS'(cy);
        r.rx    = RADIUS_BITS'(rx);
        r.ry    = RADIUS_BITS'(ry);
        r.color = COLOR_BITS'(color);
        r.y     = RADIUS_BITS'(y);
        r.drain = drain;
        row_reqs.push_back(r);
    endtask

    task automatic queue_ellipse(input int rx, input int ry, input int rows,
                                 input bit broken, input bit drain);
        int cx;
        int cy;
        int color;
        int y;
        cx    = $urandom_range(0, COORD_MAX);
        cy    = $urandom_range(0, COORD_MAX);
        color = $urandom_range(0, COLOR_MAX);
        y     = 0;
        queue_row(cx, cy, rx, ry, color, 0, drain);
        while (y < rows) begin
            y += (broken && $urandom_range(0, 2) == 0) ? $urandom_range(2, 4) : 1;
            if (broken && $urandom_range(0, 5) == 0) begin
                rx = $urandom_range(0, 63);
                ry = $urandom_range(0, 63);
            end
            queue_row(cx, cy, rx, ry, color, y);
        end
    endtask

    // Monitor: check output beats, predict on input beats, watch for a hang.
    always @(posedge i_clk) begin
        t_span    got;
        t_span    want;
        t_row_req req;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got.row   = o_span_row;
                got.left  = o_span_left;
                got.right = o_span_right;
                got.color = o_span_color;
                got.last  = o_span_last;
                if (expected_spans.size() == 0) begin
                    note_error($sformatf(
                        "unexpected span: row %0d left %0d right %0d color %0d last %0b",
                        got.row, got.left, got.right, got.color, got.last));
                end else begin
                    want = expected_spans.pop_front();
                    if (got.row !== want.row || got.left !== want.left ||
                        got.right !== want.right || got.color !== want.color ||
                        got.last !== want.last) begin
                        note_error($sformatf({"span mismatch: expected row %0d left %0d ",
                            "right %0d color %0d last %0b, got row %0d left %0d ",
                            "right %0d color %0d last %0b"},
                            want.row, want.left, want.right, want.color, want.last,
                            got.row, got.left, got.right, got.color, got.last));
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                req.cx    = i_center_x;
                req.cy    = i_center_y;
                req.rx    = i_radius_horizontal;
                req.ry    = i_radius_vertical;
                req.color = i_fill_color;
                req.y     = i_row_offset;
                req.drain = 1'b0;
                predict_spans(req);
                in_beat_taken = 1'b1;
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL filled_ellipse_span_generator_top");
                $finish;
            end
        end
    end

    // Driver: send row requests in bursts, hold a beat until taken.
    always @(negedge i_clk) begin
        t_row_req req;
        logic     drive_valid;
        drive_valid   = i_in_valid && !in_beat_taken;
        in_beat_taken = 1'b0;
        if (i_rst_n && !drive_valid) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (row_reqs.size() != 0 &&
                         (!row_reqs[0].drain || expected_spans.size() == 0)) begin
                req = row_reqs.pop_front();
                i_center_x          <= req.cx;
                i_center_y          <= req.cy;
                i_radius_horizontal <= req.rx;
                i_radius_vertical   <= req.ry;
                i_fill_color        <= req.color;
                i_row_offset        <= req.y;
                drive_valid = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 15);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
        i_in_valid <= drive_valid;
    end

    // Receiver: switch between stall patterns every so often.
    always @(negedge i_clk) begin
        logic take;
        if (ready_count == 0) begin
            ready_mode  = t_ready_mode'($urandom_range(0, 3));
            ready_count = $urandom_range(32, 200);
        end else begin
            ready_count--;
        end
        case (ready_mode)
            READY_ALWAYS: begin
                take = 1'b1;
            end
            READY_COIN: begin
                take = 1'($urandom_range(0, 1));
            end
            READY_ONE_IN_FOUR: begin
                take = (ready_count % 4 == 0);
            end
            default: begin
                if (stall_left != 0) begin
                    stall_left--;
                    take = 1'b0;
                end else begin
                    stall_left = $urandom_range(0, 25);
                    take = 1'b1;
                end
            end
        endcase
        i_out_ready <= take;
    end

    initial begin
        int pick;
        int rx;
        int ry;
        bit first;

        queue_row(0, 0, 3, 7, 8'h0F, 5);
        queue_row(COORD_MAX, COORD_MAX, RADIUS_MAX, RADIUS_MAX, COLOR_MAX, 0);
        queue_row(COORD_MAX, COORD_MAX, RADIUS_MAX, RADIUS_MAX, COLOR_MAX, 1);
        queue_row(0, 0, RADIUS_MAX, 1, 0, 0);
        queue_row(0, 0, RADIUS_MAX, 1, 0, 1);
        queue_row(0, 0, RADIUS_MAX, 1, 0, 2);
        queue_row(512, 512, 0, 0, 8'hAA, 0);
        queue_row(512, 512, 0, 0, 8'hAA, 1);
        for (int y = 0; y <= 3; y++) queue_row(100, 200, 5, 3, 8'h55, y);
        queue_row(100, 200, 9, 6, 8'h55, 4);
        queue_row(700, 300, 256, 300, 8'h81, 300);
        queue_row(511, 10, 256, 384, 8'h7E, 0);
        queue_row(511, 10, 256, 384, 8'h7E, 2);
        queue_row(3, 1020, 20, 20, 8'hC3, RADIUS_MAX);
        queue_row(COORD_MAX, 0, RADIUS_MAX, 0, 8'h3C, 0);
        queue_row(COORD_MAX, 0, RADIUS_MAX, 0, 8'h3C, 1);

        first = 1'b1;
        while (row_reqs.size() < ITEM_TARGET) begin
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
                ry = $urandom_range(0, 30);
                queue_ellipse($urandom_range(0, 30), ry, ry, 1'b0,
                              first || $urandom_range(0, 30) == 0);
            end else if (pick == 12) begin
                ry = $urandom_range(0, 10);
                queue_ellipse($urandom_range(256, RADIUS_MAX), ry, ry, 1'b0, first);
            end else if (pick == 13) begin
                queue_ellipse($urandom_range(0, 40), $urandom_range(256, RADIUS_MAX),
                              $urandom_range(4, 20), 1'b0, first);
            end else if (pick < 17) begin
                ry = $urandom_range(0, 20);
                queue_ellipse($urandom_range(0, 40), ry, ry + $urandom_range(0, 4), 1'b1,
                              first || $urandom_range(0, 20) == 0);
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    queue_row($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                              $urandom_range(0, RADIUS_MAX), $urandom_range(0, RADIUS_MAX),
                              $urandom_range(0, COLOR_MAX),
                              ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, RADIUS_MAX),
                              first);
                end
            end
            first = 1'b0;
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (row_reqs.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_spans.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (span_errors == 0) begin
            $display("PASS filled_ellipse_span_generator_top");
        end else begin
            $display("FAIL filled_ellipse_span_generator_top");
        end
        $finish;
    end

endmodule
